@@ sv/longest_prefix_match_router_core_defines.svh @@
// ----------------------------------------------------------------------------
// LPM router assertion macros
// Shared property shapes for the forwarding core checks.
// ----------------------------------------------------------------------------
`ifndef LONGEST_PREFIX_MATCH_ROUTER_CORE_DEFINES_SVH
`define LONGEST_PREFIX_MATCH_ROUTER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LPMR_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define LPMR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/lpmr_pkg.sv @@
// ----------------------------------------------------------------------------
// LPM router package
// Request, response and chain token types shared by the forwarding core.
// ----------------------------------------------------------------------------
package lpmr_pkg;

	localparam int ADDR_W = 32;
	localparam int LEN_W  = 6;
	localparam int PORT_W = 3;
	localparam int TTL_W  = 8;

	localparam logic [LEN_W-1:0] MAX_LEN = 6'd32;
	// Interfaces at or above this count do not exist.
	localparam logic [6:0] NUM_PORTS = 7'd8;

	typedef enum logic {
		KIND_ADD   = 1'b0,
		KIND_ROUTE = 1'b1
	} kind_t;

	typedef enum logic [2:0] {
		ST_ADDED       = 3'd0,
		ST_FULL        = 3'd1,
		ST_FORWARDED   = 3'd2,
		ST_NO_ROUTE    = 3'd3,
		ST_TTL_EXPIRED = 3'd4
	} status_t;

	typedef struct packed {
		kind_t              kind;
		logic [ADDR_W-1:0]  net_prefix;
		logic [LEN_W-1:0]   prefix_len;
		logic               has_next_hop;
		logic [ADDR_W-1:0]  next_hop_in;
		logic [PORT_W-1:0]  interface_in;
		logic [ADDR_W-1:0]  dst_addr;
		logic [TTL_W-1:0]   ttl_in;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [PORT_W-1:0]  out_interface;
		logic [ADDR_W-1:0]  next_hop_out;
		logic [TTL_W-1:0]   ttl_out;
	} rsp_t;

	// Request as it travels down the cell chain, with the best match so far.
	typedef struct packed {
		kind_t              kind;
		logic               full;
		logic [ADDR_W-1:0]  prefix;
		logic [LEN_W-1:0]   len;
		logic               has_hop;
		logic [ADDR_W-1:0]  hop;
		logic [PORT_W-1:0]  port;
		logic [ADDR_W-1:0]  dst;
		logic [TTL_W-1:0]   ttl;
		logic               found;
		logic [LEN_W-1:0]   best_len;
		logic               best_has_hop;
		logic [ADDR_W-1:0]  best_hop;
		logic [PORT_W-1:0]  best_port;
	} tok_t;

endpackage

@@ sv/lpmr_cell.sv @@
// ----------------------------------------------------------------------------
// LPM router cell
// Holds one route, stores it when its add request passes, and folds it into
// the best match of each lookup request that passes.
// ----------------------------------------------------------------------------
module lpmr_cell #(
	parameter int INDEX = 0,
	parameter int CNT_W = 5
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  logic                 valid_in,
	input  lpmr_pkg::tok_t       tok_in,
	input  logic [CNT_W-1:0]     cnt_in,
	output logic                 valid_out,
	output lpmr_pkg::tok_t       tok_out,
	output logic [CNT_W-1:0]     cnt_out
);

	localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

	logic [lpmr_pkg::ADDR_W-1:0] prefix_q;
	logic [lpmr_pkg::LEN_W-1:0]  len_q;
	logic                        has_hop_q;
	logic [lpmr_pkg::ADDR_W-1:0] hop_q;
	logic [lpmr_pkg::PORT_W-1:0] port_q;

	logic                        valid_s1;
	lpmr_pkg::tok_t              tok_s1;
	logic [CNT_W-1:0]            cnt_s1;

	logic [lpmr_pkg::ADDR_W-1:0] mask;
	logic                        hit;
	logic                        take;
	logic                        write_en;
	lpmr_pkg::tok_t              tok_d;

	always_comb begin
		mask = ~({lpmr_pkg::ADDR_W{1'b1}} >> len_q);
		// Only routes added before this lookup entered take part.
		hit = valid_in && (tok_in.kind == lpmr_pkg::KIND_ROUTE) && (IDX < cnt_in)
			&& (((prefix_q ^ tok_in.dst) & mask) == '0);
		take = hit && (!tok_in.found || (tok_in.best_len < len_q));
		write_en = advance && valid_in && (tok_in.kind == lpmr_pkg::KIND_ADD)
			&& !tok_in.full && (cnt_in == IDX);
		tok_d = tok_in;
		if (take) begin
			tok_d.found        = 1'b1;
			tok_d.best_len     = len_q;
			tok_d.best_has_hop = has_hop_q;
			tok_d.best_hop     = hop_q;
			tok_d.best_port    = port_q;
		end
	end

	always_ff @(posedge clk) begin
		if (write_en) begin
			prefix_q  <= tok_in.prefix;
			len_q     <= tok_in.len;
			has_hop_q <= tok_in.has_hop;
			hop_q     <= tok_in.hop;
			port_q    <= tok_in.port;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			tok_s1 <= tok_d;
			cnt_s1 <= cnt_in;
		end
	end

	assign valid_out = valid_s1;
	assign tok_out   = tok_s1;
	assign cnt_out   = cnt_s1;

endmodule

@@ sv/lpmr_resolve.sv @@
// ----------------------------------------------------------------------------
// LPM router resolve stage
// Turns the chain's final token into a response and holds it in the output
// register until the receiver takes it.
// ----------------------------------------------------------------------------
module lpmr_resolve (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid_in,
	input  lpmr_pkg::tok_t   tok_in,
	input  logic             rsp_stall,
	output logic             advance,
	output logic             rsp_valid,
	output lpmr_pkg::rsp_t   rsp
);

	logic            valid_q;
	lpmr_pkg::rsp_t  rsp_q;
	lpmr_pkg::rsp_t  rsp_d;
	logic            port_ok;

	always_comb begin
		port_ok = {4'b0, tok_in.best_port} < lpmr_pkg::NUM_PORTS;
		rsp_d = '0;
		if (tok_in.kind == lpmr_pkg::KIND_ADD) begin
			rsp_d.status = tok_in.full ? lpmr_pkg::ST_FULL : lpmr_pkg::ST_ADDED;
		end else if (!tok_in.found || !port_ok) begin
			rsp_d.status = lpmr_pkg::ST_NO_ROUTE;
		end else if (tok_in.ttl <= 8'd1) begin
			rsp_d.status = lpmr_pkg::ST_TTL_EXPIRED;
		end else begin
			rsp_d.status        = lpmr_pkg::ST_FORWARDED;
			rsp_d.out_interface = tok_in.best_port;
			// Direct route: deliver to the destination itself.
			rsp_d.next_hop_out  = tok_in.best_has_hop ? tok_in.best_hop : tok_in.dst;
			rsp_d.ttl_out       = tok_in.ttl - 8'd1;
		end
	end

	// Advance the whole chain whenever the output register is free or taken.
	assign advance = !valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = valid_q;
	assign rsp       = rsp_q;

endmodule

@@ sv/longest_prefix_match_router_core.sv @@
// ----------------------------------------------------------------------------
// Longest prefix match router core
// IPv4 forwarding table built as a chain of route cells.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid, req_stall, req): an add request appends one
//   route; a route request looks up dst_addr and, when forwarded, decrements ttl_in.
//   Response channel (rsp_valid, rsp_stall, rsp): exactly one response per
//   request, in request order.
//   Each request walks a chain of MAX_ROUTES cells, one cell per cycle while
//   the chain advances, each cell holding one route, and the resolve stage
//   registers its response. A new request enters every cycle unless req_stall
//   is raised; sustained throughput is one request per cycle while unstalled.
//   An add request takes its table slot as it enters; the route lands in its
//   cell as the request passes, ahead of any later lookup.
//   Reset clears the route count and all stage valids; route storage is left
//   as is and only slots below the count are ever matched.
//   While rsp_valid is high and rsp_stall is high the whole chain holds and
//   req_stall is raised; the held response stays unchanged.
// ----------------------------------------------------------------------------
`include "longest_prefix_match_router_core_defines.svh"

module longest_prefix_match_router_core #(
	parameter int MAX_ROUTES = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  lpmr_pkg::req_t   req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output lpmr_pkg::rsp_t   rsp
);

	localparam int CNT_W = $clog2(MAX_ROUTES + 1);
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ROUTES);

	logic                  advance;
	logic                  accept;
	logic                  add_ok;
	logic [CNT_W-1:0]      count_q;
	lpmr_pkg::tok_t        tok_head;

	logic [MAX_ROUTES:0]   vld_w;
	lpmr_pkg::tok_t        tok_w [MAX_ROUTES+1];
	logic [CNT_W-1:0]      cnt_w [MAX_ROUTES+1];

	assign req_stall = !advance;
	assign accept    = req_valid && advance;
	assign add_ok    = accept && (req.kind == lpmr_pkg::KIND_ADD) && (count_q != MAX_CNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (add_ok) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	// Build the chain token from the incoming request.
	always_comb begin
		tok_head         = '0;
		tok_head.kind    = req.kind;
		tok_head.full    = (count_q == MAX_CNT);
		tok_head.prefix  = req.net_prefix;
		tok_head.len     = (req.prefix_len > lpmr_pkg::MAX_LEN) ? lpmr_pkg::MAX_LEN
			: req.prefix_len;
		tok_head.has_hop = req.has_next_hop;
		tok_head.hop     = req.next_hop_in;
		tok_head.port    = req.interface_in;
		tok_head.dst     = req.dst_addr;
		tok_head.ttl     = req.ttl_in;
	end

	assign tok_w[0] = tok_head;
	assign vld_w[0] = req_valid;
	assign cnt_w[0] = count_q;

	for (genvar i = 0; i < MAX_ROUTES; i++) begin : g_cell
		lpmr_cell #(
			.INDEX (i),
			.CNT_W (CNT_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.advance   (advance),
			.valid_in  (vld_w[i]),
			.tok_in    (tok_w[i]),
			.cnt_in    (cnt_w[i]),
			.valid_out (vld_w[i+1]),
			.tok_out   (tok_w[i+1]),
			.cnt_out   (cnt_w[i+1])
		);
	end

	lpmr_resolve u_resolve (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_in  (vld_w[MAX_ROUTES]),
		.tok_in    (tok_w[MAX_ROUTES]),
		.rsp_stall (rsp_stall),
		.advance   (advance),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

	`LPMR_ASSERT_IMPLY(a_count_bound, 1'b1, count_q <= MAX_CNT, "route count above table size")
	`LPMR_ASSERT_NEXT(a_count_step, add_ok, count_q == $past(count_q) + CNT_W'(1), "add took no slot")
	`LPMR_ASSERT_IMPLY(a_stall_cause, req_stall, rsp_valid && rsp_stall, "stall with output free")
	`LPMR_ASSERT_IMPLY(a_fwd_ttl, rsp_valid && (rsp.status == lpmr_pkg::ST_FORWARDED), rsp.ttl_out != 8'd0, "forwarded with zero ttl")
	`LPMR_ASSERT_IMPLY(a_nofwd_zero, rsp_valid && (rsp.status != lpmr_pkg::ST_FORWARDED), (rsp.out_interface == 3'd0) && (rsp.next_hop_out == 32'd0) && (rsp.ttl_out == 8'd0), "non-forwarded response carries data")

endmodule
